/* rtl/core/nst_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nst_pkg - NMEA sentence tokenizer types and constants
// Item, result and tokenizer state types shared by the tokenizer modules.
// ----------------------------------------------------------------------------
package nst_pkg;

  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharComma  = 8'h2C;
  localparam logic [7:0] CharStar   = 8'h2A;

  // Results one request can produce: two delayed bytes, the end byte, the close.
  localparam int unsigned NumSlots = 4;
  localparam int unsigned SlotIdxW = 2;
  localparam int unsigned SlotCntW = 3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_sentence;
  } in_item_t;

  typedef struct packed {
    logic [7:0] token_number;
    logic [7:0] token_start;
    logic [7:0] token_length;
    logic       kept;
    logic       has_token;
    logic       final_token;
  } res_t;

  typedef struct packed {
    logic [7:0] offset;
    logic [7:0] cur_start;
    logic [7:0] tokens_seen;
    logic [7:0] token_len;
    logic [7:0] last_comma;
    logic       any_processed;
  } tok_state_t;

  typedef struct packed {
    logic            at_start;
    logic [1:0][7:0] dly;
    logic [1:0]      dly_cnt;
    tok_state_t      tok;
  } nst_state_t;

  localparam nst_state_t StateReset = '{at_start: 1'b1, dly: '0, dly_cnt: '0, tok: '0};

endpackage

/* rtl/core/nst_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nst_stream_if - valid/ready stream channel
// One request moves when valid and ready are both high at a clock edge.
// ----------------------------------------------------------------------------
interface nst_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/nst_token_logic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nst_token_logic - tokenizer next-state and result logic
// From the current state and one byte, forms the next state and up to four
// token results in one pass.
// ----------------------------------------------------------------------------
module nst_token_logic import nst_pkg::*; #(
  parameter int unsigned MAX_TOKENS         = 32,
  parameter int unsigned MAX_SENTENCE_BYTES = 256
) (
  input  nst_state_t                  state_i,
  input  in_item_t                    item_i,
  output nst_state_t                  state_o,
  output res_t [NumSlots-1:0]         res_o,
  output logic [SlotCntW-1:0]         res_cnt_o
);

  localparam logic [7:0] OffLimit = 8'(MAX_SENTENCE_BYTES - 1);
  localparam logic [7:0] MaxTok   = 8'(MAX_TOKENS);

  typedef struct packed {
    tok_state_t tok;
    logic       emit;
    res_t       res;
  } proc_t;

  function automatic logic [7:0] off_inc(input logic [7:0] v);
    return (v < OffLimit) ? v + 8'd1 : OffLimit;
  endfunction

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v != 8'hFF) ? v + 8'd1 : v;
  endfunction

  function automatic proc_t proc_byte(input tok_state_t t, input logic [7:0] b);
    proc_t p;
    p      = '0;
    p.tok  = t;
    if (b == CharComma) begin
      p.emit                 = 1'b1;
      p.res.token_number     = t.tokens_seen;
      p.res.token_start      = t.cur_start;
      p.res.token_length     = t.token_len;
      p.res.kept             = (t.tokens_seen < MaxTok);
      p.res.has_token        = 1'b1;
      p.tok.tokens_seen      = sat_inc(t.tokens_seen);
      p.tok.last_comma       = t.offset;
      p.tok.cur_start        = off_inc(t.offset);
      p.tok.token_len        = '0;
    end else begin
      p.tok.token_len        = sat_inc(t.token_len);
    end
    p.tok.any_processed = 1'b1;
    p.tok.offset        = off_inc(t.offset);
    return p;
  endfunction

  function automatic res_t finish_res(input tok_state_t t);
    res_t r;
    r = '0;
    if (t.any_processed) begin
      r.token_number = t.tokens_seen;
      r.kept         = (t.tokens_seen < MaxTok);
      r.has_token    = 1'b1;
      if (t.token_len == 8'd0) begin
        r.token_start = t.last_comma;
      end else begin
        r.token_start  = t.cur_start;
        r.token_length = t.token_len;
      end
    end
    r.final_token = 1'b1;
    return r;
  endfunction

  always_comb begin
    tok_state_t          cur;
    proc_t               p;
    res_t [NumSlots-1:0] r;
    logic [SlotCntW-1:0] n;
    logic                drop;
    state_o = state_i;
    cur     = state_i.tok;
    r       = '0;
    n       = '0;
    p       = '0;
    drop    = 1'b0;
    if (state_i.at_start && (item_i.data_byte == CharDollar)) begin
      state_o.at_start      = 1'b0;
      state_o.tok.offset    = 8'd1;
      state_o.tok.cur_start = 8'd1;
      if (item_i.end_of_sentence) begin
        r[0]    = finish_res(StateReset.tok);
        n       = SlotCntW'(1);
        state_o = StateReset;
      end
    end else begin
      state_o.at_start = 1'b0;
      if (item_i.end_of_sentence) begin
        drop = state_i.dly_cnt[1] && (state_i.dly[0] == CharStar);
        if (!drop) begin
          if (state_i.dly_cnt != 2'd0) begin
            p   = proc_byte(cur, state_i.dly[0]);
            cur = p.tok;
            if (p.emit) begin
              r[n[SlotIdxW-1:0]] = p.res;
              n = n + SlotCntW'(1);
            end
          end
          if (state_i.dly_cnt[1]) begin
            p   = proc_byte(cur, state_i.dly[1]);
            cur = p.tok;
            if (p.emit) begin
              r[n[SlotIdxW-1:0]] = p.res;
              n = n + SlotCntW'(1);
            end
          end
          p   = proc_byte(cur, item_i.data_byte);
          cur = p.tok;
          if (p.emit) begin
            r[n[SlotIdxW-1:0]] = p.res;
            n = n + SlotCntW'(1);
          end
        end
        r[n[SlotIdxW-1:0]] = finish_res(cur);
        n       = n + SlotCntW'(1);
        state_o = StateReset;
      end else if (state_i.dly_cnt[1]) begin
        p = proc_byte(cur, state_i.dly[0]);
        if (p.emit) begin
          r[0] = p.res;
          n    = SlotCntW'(1);
        end
        state_o.tok    = p.tok;
        state_o.dly[0] = state_i.dly[1];
        state_o.dly[1] = item_i.data_byte;
      end else begin
        state_o.dly[state_i.dly_cnt[0]] = item_i.data_byte;
        state_o.dly_cnt                 = state_i.dly_cnt + 2'd1;
      end
    end
    res_o     = r;
    res_cnt_o = n;
  end

endmodule

/* rtl/core/nmea_sentence_tokenizer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_sentence_tokenizer_unit - NMEA sentence field tokenizer
// Splits a byte stream of NMEA sentences into comma-separated tokens.
// ----------------------------------------------------------------------------
// One sentence byte is taken per request, the last one marked. A leading '$'
// is skipped and a trailing "*XX" checksum is dropped (not verified); the
// body is split at commas into tokens given as start offset, length and
// index, with kept cleared for tokens at or beyond MAX_TOKENS. Ordinary bytes
// are taken at one per cycle when results are taken without stall and give
// zero or one token; the end byte gives one to four tokens, which leave one
// per cycle from a four-entry result buffer while the output is not stalled.
// A new byte is taken while the last buffered result sits in the output
// register. Results pass through the result buffer, then the output register.
// ----------------------------------------------------------------------------
module nmea_sentence_tokenizer_unit import nst_pkg::*; #(
  parameter int unsigned MAX_TOKENS         = 32,
  parameter int unsigned MAX_SENTENCE_BYTES = 256
) (
  input logic         clk_i,
  input logic         rst_ni,
  nst_stream_if.sink   in_i,
  nst_stream_if.source out_o
);

  nst_state_t              state_q, state_d;
  res_t [NumSlots-1:0]     res;
  logic [SlotCntW-1:0]     res_cnt;
  res_t [NumSlots-1:0]     bun_q;
  logic [SlotCntW-1:0]     bun_left_q;
  logic [SlotIdxW-1:0]     rd_q;
  res_t                    out_q;
  logic                    out_vld_q;
  logic                    load_out;
  logic                    in_acc;
  in_item_t                item;

  assign item = in_i.payload;

  nst_token_logic #(
    .MAX_TOKENS        (MAX_TOKENS),
    .MAX_SENTENCE_BYTES(MAX_SENTENCE_BYTES)
  ) u_logic (
    .state_i  (state_q),
    .item_i   (item),
    .state_o  (state_d),
    .res_o    (res),
    .res_cnt_o(res_cnt)
  );

  assign load_out   = (bun_left_q != '0) && (!out_vld_q || out_o.ready);
  assign in_i.ready = (bun_left_q == '0) ||
                      ((bun_left_q == SlotCntW'(1)) && load_out);
  assign in_acc     = in_i.valid && in_i.ready;

  assign out_o.valid   = out_vld_q;
  assign out_o.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StateReset;
      bun_left_q <= '0;
      rd_q       <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        state_q    <= state_d;
        bun_left_q <= res_cnt;
        rd_q       <= '0;
      end else if (load_out) begin
        bun_left_q <= bun_left_q - SlotCntW'(1);
        rd_q       <= rd_q + SlotIdxW'(1);
      end
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (res_cnt != '0)) begin
      bun_q <= res;
    end
    if (load_out) begin
      out_q <= bun_q[rd_q];
    end
  end

  a_bun_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    bun_left_q <= SlotCntW'(NumSlots))
    else $error("result buffer count out of range");

  a_eos_emits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && item.end_of_sentence |-> res_cnt != '0)
    else $error("sentence end produced no result");

  a_eos_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && item.end_of_sentence |=> state_q.at_start && state_q.dly_cnt == 2'd0)
    else $error("state not cleared after sentence end");

  a_dly_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.dly_cnt != 2'd3)
    else $error("delay line count out of range");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - testbench for nmea_sentence_tokenizer_unit
// Feeds NMEA sentence bytes through the input stream: short directed cases,
// longer sentences, an output hold-off and random sentences and noise. A
// local tokenizer works out the expected tokens, and each token that leaves
// the unit is checked against the oldest one still pending.
// ----------------------------------------------------------------------------
module tb_top;
  import nst_pkg::*;

  localparam int unsigned MaxTokens        = 32;
  localparam int unsigned MaxSentenceBytes = 256;
  localparam logic [7:0]  OffLimit         = 8'(MaxSentenceBytes - 1);
  localparam int unsigned IdleLimit        = 2000;

  logic clk_i;
  logic rst_ni;

  nst_stream_if #(.payload_t(in_item_t)) in_if ();
  nst_stream_if #(.payload_t(res_t))     out_if ();

  nmea_sentence_tokenizer_unit #(
    .MAX_TOKENS         (MaxTokens),
    .MAX_SENTENCE_BYTES (MaxSentenceBytes)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // tokenizer state
  logic       at_start_m;
  logic [7:0] offset_m;
  logic [7:0] body_cnt_m;
  logic [7:0] dly_m [2];
  logic [1:0] dly_cnt_m;
  logic [7:0] cur_start_m;
  logic [7:0] seen_m;
  logic [7:0] len_m;
  logic [7:0] comma_m;
  logic       any_m;

  res_t       pending_tokens[$];
  logic [7:0] sentence_buf[$];

  int  mismatches;
  int  idle_cycles;
  int  hold_len;
  int  hold_left;
  int  stall_left;
  bit  calm;

  function automatic logic [7:0] bump_offset(input logic [7:0] v);
    return (v < OffLimit) ? v + 8'd1 : OffLimit;
  endfunction

  function automatic logic [7:0] bump_sat(input logic [7:0] v);
    return (v != 8'hFF) ? v + 8'd1 : 8'hFF;
  endfunction

  function automatic void clear_sentence();
    at_start_m  = 1'b1;
    offset_m    = '0;
    body_cnt_m  = '0;
    dly_m[0]    = '0;
    dly_m[1]    = '0;
    dly_cnt_m   = '0;
    cur_start_m = '0;
    seen_m      = '0;
    len_m       = '0;
    comma_m     = '0;
    any_m       = 1'b0;
  endfunction

  function automatic void emit_token(input logic [7:0] start, input logic [7:0] len);
    res_t r;
    r.token_number = seen_m;
    r.token_start  = start;
    r.token_length = len;
    r.kept         = (seen_m < MaxTokens);
    r.has_token    = 1'b1;
    r.final_token  = 1'b0;
    pending_tokens.push_back(r);
    seen_m = bump_sat(seen_m);
  endfunction

  function automatic void scan_char(input logic [7:0] b);
    if (b == CharComma) begin
      emit_token(cur_start_m, len_m);
      comma_m     = offset_m;
      cur_start_m = bump_offset(offset_m);
      len_m       = '0;
    end else begin
      len_m = bump_sat(len_m);
    end
    any_m    = 1'b1;
    offset_m = bump_offset(offset_m);
  endfunction

  function automatic void close_sentence();
    res_t r;
    if (!any_m) begin
      r = '0;
      pending_tokens.push_back(r);
    end else if (len_m == 8'd0) begin
      emit_token(comma_m, 8'd0);
    end else begin
      emit_token(cur_start_m, len_m);
    end
    pending_tokens[pending_tokens.size() - 1].final_token = 1'b1;
    clear_sentence();
  endfunction

  function automatic void tokenize_byte(input logic [7:0] b, input logic eos);
    int i;
    if (at_start_m) begin
      at_start_m = 1'b0;
      if (b == CharDollar) begin
        offset_m    = 8'd1;
        cur_start_m = 8'd1;
        if (eos) close_sentence();
        return;
      end
    end
    body_cnt_m = bump_sat(body_cnt_m);
    if (eos) begin
      // a trailing "*XX" is dropped unseen
      if (!(dly_cnt_m >= 2 && dly_m[0] == CharStar)) begin
        for (i = 0; i < int'(dly_cnt_m); i++) scan_char(dly_m[i]);
        scan_char(b);
      end
      close_sentence();
      return;
    end
    if (dly_cnt_m >= 2) begin
      scan_char(dly_m[0]);
      dly_m[0] = dly_m[1];
      dly_m[1] = b;
    end else begin
      dly_m[dly_cnt_m[0]] = b;
      dly_cnt_m = dly_cnt_m + 2'd1;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    rst_ni        = 1'b0;
    hold_len      = 0;
    calm          = 1'b0;
    mismatches    = 0;
    clear_sentence();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // result side ready
  initial begin
    out_if.ready = 1'b0;
    hold_left    = 0;
    stall_left   = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_len != 0) begin
        hold_left = hold_len;
        hold_len  = 0;
      end
      if (hold_left != 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.payload;
      if (pending_tokens.size() == 0) begin
        if (mismatches < 10)
          $display("%0t unexpected token: num %0d start %0d len %0d", $realtime,
                   got.token_number, got.token_start, got.token_length);
        mismatches++;
      end else begin
        want = pending_tokens.pop_front();
        if (got.token_number !== want.token_number ||
            got.token_start !== want.token_start ||
            got.token_length !== want.token_length ||
            got.kept !== want.kept || got.has_token !== want.has_token ||
            got.final_token !== want.final_token) begin
          if (mismatches < 10) begin
            $display("%0t token mismatch: exp num %0d start %0d len %0d kept %b has %b fin %b",
                     $realtime, want.token_number, want.token_start, want.token_length,
                     want.kept, want.has_token, want.final_token);
            $display("                      got num %0d start %0d len %0d kept %b has %b fin %b",
                     got.token_number, got.token_start, got.token_length,
                     got.kept, got.has_token, got.final_token);
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t timeout, %0d tokens pending", $realtime, pending_tokens.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    in_if.valid   <= 1'b1;
    in_if.payload <= '{data_byte: b, end_of_sentence: eos};
    do @(posedge clk_i); while (!in_if.ready);
    tokenize_byte(b, eos);
    gap = pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_sentence();
    int i;
    for (i = 0; i < sentence_buf.size(); i++)
      send_byte(sentence_buf[i], i == sentence_buf.size() - 1);
  endtask

  task automatic load_str(input string s);
    int i;
    sentence_buf.delete();
    for (i = 0; i < s.len(); i++) sentence_buf.push_back(s[i]);
  endtask

  task automatic send_str(input string s);
    load_str(s);
    send_sentence();
  endtask

  // lone '$', checksum-only body, single body byte, empty and trailing
  // fields, checksum drop, missing '$', bare "*XY" body
  task automatic test_special_cases();
    send_str("$");
    send_str("$*AB");
    send_str("X");
    send_str("$,B,");
    send_str("$A,B*7C");
    send_str("GP,1");
    send_str("*XY");
  endtask

  // token count past MAX_TOKENS, longer fields with and without '$'
  task automatic test_long_sentences();
    int i;
    sentence_buf.delete();
    sentence_buf.push_back(CharDollar);
    for (i = 0; i < 36; i++) sentence_buf.push_back(CharComma);
    send_sentence();
    sentence_buf.delete();
    sentence_buf.push_back(CharDollar);
    for (i = 0; i < 12; i++) sentence_buf.push_back(8'h41 + 8'(i % 26));
    sentence_buf.push_back(CharStar);
    sentence_buf.push_back("0");
    sentence_buf.push_back("0");
    send_sentence();
    sentence_buf.delete();
    for (i = 0; i < 8; i++) sentence_buf.push_back("K");
    sentence_buf.push_back(CharComma);
    for (i = 0; i < 8; i++) sentence_buf.push_back("Z");
    send_sentence();
  endtask

  // result side held off while the sender keeps offering comma bytes
  task automatic test_output_hold();
    calm     = 1'b1;
    hold_len = 80;
    send_str("$GPGSV,,,,,,,,,,,,,,,,,A*5E");
    send_str("$,,,,,,,,");
    calm = 1'b0;
  endtask

  task automatic build_sentence();
    string field_chars;
    string hex_chars;
    int    nfields;
    int    flen;
    int    f;
    int    c;
    int    tail;
    field_chars = "ABCDEGLMNPRSTVW0123456789.-";
    hex_chars   = "0123456789ABCDEF";
    sentence_buf.delete();
    if ($urandom_range(0, 9) != 0) sentence_buf.push_back(CharDollar);
    nfields = $urandom_range(1, 7);
    for (f = 0; f < nfields; f++) begin
      if (f != 0) sentence_buf.push_back(CharComma);
      flen = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      for (c = 0; c < flen; c++)
        sentence_buf.push_back(field_chars[$urandom_range(0, field_chars.len() - 1)]);
    end
    if ($urandom_range(0, 4) == 0) sentence_buf.push_back(CharComma);
    tail = $urandom_range(0, 9);
    if (tail < 6) begin
      sentence_buf.push_back(CharStar);
      sentence_buf.push_back(hex_chars[$urandom_range(0, 15)]);
      sentence_buf.push_back(hex_chars[$urandom_range(0, 15)]);
    end else if (tail < 8) begin
      sentence_buf.push_back(CharStar);
      sentence_buf.push_back(hex_chars[$urandom_range(0, 15)]);
    end
  endtask

  task automatic test_random_sentences();
    int sent;
    sent = 0;
    while (sent < 15) begin
      calm = ($urandom_range(0, 4) == 0);
      build_sentence();
      sent += sentence_buf.size();
      send_sentence();
    end
    calm = 1'b0;
  endtask

  task automatic test_noise();
    int i;
    for (i = 0; i < 10; i++)
      send_byte(8'($urandom_range(0, 255)), (i == 9) || ($urandom_range(0, 4) == 0));
  endtask

  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    test_special_cases();
    test_long_sentences();
    test_output_hold();
    test_random_sentences();
    test_noise();
    in_if.valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
